/* sv/lhe_pkg.sv */
// Shared constants and types for the letter histogram entropy block.
package lhe_pkg;

   localparam int NUM_BINS_DEF   = 26;
   localparam int COUNT_BITS_DEF = 24;
   localparam int IDX_BITS       = 5;
   localparam int CNT_OUT_BITS   = 24;
   localparam int PROB_BITS      = 17;
   localparam int ENT_BITS       = 19;
   localparam int LOG_FRAC       = 26;
   localparam int LOG_BITS       = 31;
   localparam logic [ENT_BITS-1:0] ENTROPY_MAX = 19'd327680;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic count_en;
      logic load_bin;
      logic log_start;
      logic div_start;
      logic accum;
      logic emit;
      logic final_div;
      logic clear;
   } lhe_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic log_done;
      logic div_done;
   } lhe_sts_type;

endpackage

/* sv/letter_histogram_entropy_top.sv */
// Top level of the letter histogram entropy block.
//
//   Channel  Ports                               Handshake
//   req      req_data_byte, req_block_end        start & !busy
//   rsp      rsp_letter_index .. rsp_result_last rsp_valid, one cycle each
//
// Letter bytes are counted one per cycle while busy is low. The byte that ends a
// block raises busy; the block then evaluates the 26 bins one after another.
// Each bin takes a log2 (a scan down to the leading one, then a square and an
// adjust step per fraction bit; a count of zero or one ends in the scan) and a
// restoring divide of one quotient bit per cycle (60 quotient bits at the
// default width). The entropy divide runs after the last bin.
// Reset clears all bins and the total at once. Results cannot be stalled.
module letter_histogram_entropy_top
   import lhe_pkg::*;
#(
   parameter int NUM_BINS   = NUM_BINS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_block_end,
   output logic                    rsp_valid,
   output logic [IDX_BITS-1:0]     rsp_letter_index,
   output logic [CNT_OUT_BITS-1:0] rsp_letter_count,
   output logic [PROB_BITS-1:0]    rsp_probability,
   output logic [ENT_BITS-1:0]     rsp_entropy_bits,
   output logic                    rsp_result_last
);

   lhe_cmd_type         cmd;
   lhe_sts_type         sts;
   logic [IDX_BITS-1:0] bin_sel;
   logic                first_bin, last_bin;
   logic                busy_int;

   // Counting is gated by start inside the controller's idle state, where busy is low.
   lhe_ctrl #(.NUM_BINS(NUM_BINS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .block_end(req_block_end),
      .sts(sts), .busy(busy_int), .cmd(cmd), .bin_sel(bin_sel),
      .first_bin(first_bin), .last_bin(last_bin)
   );

   lhe_datapath #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .bin_sel(bin_sel),
      .first_bin(first_bin), .last_bin(last_bin), .data_byte(req_data_byte),
      .sts(sts), .rsp_valid(rsp_valid), .rsp_letter_index(rsp_letter_index),
      .rsp_letter_count(rsp_letter_count), .rsp_probability(rsp_probability),
      .rsp_entropy_bits(rsp_entropy_bits), .rsp_result_last(rsp_result_last)
   );

   assign busy = busy_int;

endmodule

/* sv/lhe_ctrl.sv */
// Controller state machine sequencing counting, per-bin evaluation and clearing.
module lhe_ctrl
   import lhe_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                block_end,
   input  lhe_sts_type         sts,
   output logic                busy,
   output lhe_cmd_type         cmd,
   output logic [IDX_BITS-1:0] bin_sel,
   output logic                first_bin,
   output logic                last_bin
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TLOG, ST_TLOG_W, ST_LOAD, ST_LOG, ST_LOG_W, ST_DIV, ST_DIV_W,
      ST_EMIT, ST_HDIV, ST_HDIV_W, ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] bin_ff, bin_in;
   logic                busy_ff, busy_in;
   logic                first_ff, first_in;

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      busy_in  = busy_ff;
      first_in = first_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.count_en = 1'b1;
               if (block_end) begin
                  busy_in  = 1'b1;
                  state_in = ST_TLOG;
                  bin_in   = '0;
                  first_in = 1'b1;
               end
            end
         end
         ST_TLOG: begin
            cmd.log_start = 1'b1;
            state_in      = ST_TLOG_W;
         end
         ST_TLOG_W: if (sts.log_done) state_in = ST_LOAD;
         ST_LOAD: begin
            cmd.load_bin = 1'b1;
            state_in     = ST_LOG;
         end
         ST_LOG: begin
            cmd.log_start = 1'b1;
            state_in      = ST_LOG_W;
         end
         ST_LOG_W: if (sts.log_done) state_in = ST_DIV;
         ST_DIV: begin
            cmd.div_start = 1'b1;
            cmd.accum     = 1'b1;
            state_in      = ST_DIV_W;
         end
         ST_DIV_W: begin
            if (sts.div_done) begin
               if (bin_ff == IDX_BITS'(NUM_BINS - 1)) begin
                  state_in = ST_HDIV;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            first_in = 1'b0;
            bin_in   = bin_ff + 1'b1;
            state_in = ST_LOAD;
         end
         ST_HDIV: begin
            cmd.div_start = 1'b1;
            cmd.final_div = 1'b1;
            state_in      = ST_HDIV_W;
         end
         ST_HDIV_W: if (sts.div_done) state_in = ST_DONE;
         ST_DONE: begin
            cmd.emit  = 1'b1;
            cmd.clear = 1'b1;
            busy_in   = 1'b0;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bin_ff   <= '0;
         busy_ff  <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bin_ff   <= bin_in;
         busy_ff  <= busy_in;
         first_ff <= first_in;
      end
   end

   assign busy      = busy_ff;
   assign bin_sel   = bin_ff;
   assign first_bin = first_ff;
   assign last_bin  = (bin_ff == IDX_BITS'(NUM_BINS - 1));

endmodule

/* sv/lhe_log2.sv */
// Iterative log2 unit: normalizes, then squares once per fraction bit.
module lhe_log2
   import lhe_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [COUNT_BITS-1:0] x,
   output logic                done,
   output logic [LOG_BITS-1:0] result
);

   localparam int NB = $clog2(COUNT_BITS);

   typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ, L_ADJ} lstate_type;

   lstate_type            st_ff;
   logic [COUNT_BITS-1:0] x_ff;
   logic [NB-1:0]         n_ff;
   logic [32:0]           m_ff;
   logic [65:0]           prod_ff;
   logic [LOG_BITS-1:0]   r_ff;
   logic [4:0]            k_ff;
   logic                  done_ff;
   logic [32:0]           m_next;

   assign m_next = prod_ff[63:31];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (st_ff)
            L_IDLE: begin
               if (start) begin
                  x_ff  <= x;
                  n_ff  <= NB'(COUNT_BITS - 1);
                  r_ff  <= '0;
                  st_ff <= L_NORM;
               end
            end
            L_NORM: begin
               // Walk down to the leading one, one bit position a cycle.
               if (x_ff <= COUNT_BITS'(1)) begin
                  r_ff    <= '0;
                  done_ff <= 1'b1;
                  st_ff   <= L_IDLE;
               end else if (x_ff[n_ff]) begin
                  m_ff  <= 33'(x_ff) << (31 - int'(n_ff));
                  r_ff  <= LOG_BITS'(n_ff) << LOG_FRAC;
                  k_ff  <= 5'(LOG_FRAC - 1);
                  st_ff <= L_SQ;
               end else begin
                  n_ff <= n_ff - 1'b1;
               end
            end
            L_SQ: begin
               prod_ff <= 66'(m_ff) * 66'(m_ff);
               st_ff   <= L_ADJ;
            end
            L_ADJ: begin
               if (m_next[32]) begin
                  m_ff       <= m_next >> 1;
                  r_ff[k_ff] <= 1'b1;
               end else begin
                  m_ff <= m_next;
               end
               if (k_ff == '0) begin
                  done_ff <= 1'b1;
                  st_ff   <= L_IDLE;
               end else begin
                  k_ff  <= k_ff - 1'b1;
                  st_ff <= L_SQ;
               end
            end
            default: st_ff <= L_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

/* sv/lhe_div.sv */
// Restoring divider, one quotient bit per cycle.
module lhe_div
   import lhe_pkg::*;
#(
   parameter int NUM_BITS = 64,
   parameter int DEN_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);

   localparam int CB = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] q_ff;
   logic [DEN_BITS:0]   r_ff;
   logic [DEN_BITS-1:0] d_ff;
   logic [CB-1:0]       cnt_ff;
   logic                run_ff, done_ff;
   logic [DEN_BITS:0]   trial;

   assign trial = {r_ff[DEN_BITS-1:0], q_ff[NUM_BITS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            q_ff   <= numer;
            r_ff   <= '0;
            d_ff   <= denom;
            cnt_ff <= CB'(NUM_BITS);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (trial >= {1'b0, d_ff}) begin
               r_ff <= trial - {1'b0, d_ff};
               q_ff <= {q_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               r_ff <= trial;
               q_ff <= {q_ff[NUM_BITS-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CB'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

/* sv/lhe_datapath.sv */
// Datapath: bins, total, log and divide units, entropy sum and result registers.
module lhe_datapath
   import lhe_pkg::*;
#(
   parameter int NUM_BINS   = NUM_BINS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lhe_cmd_type             cmd,
   input  logic [IDX_BITS-1:0]     bin_sel,
   input  logic                    first_bin,
   input  logic                    last_bin,
   input  logic [7:0]              data_byte,
   output lhe_sts_type             sts,
   output logic                    rsp_valid,
   output logic [IDX_BITS-1:0]     rsp_letter_index,
   output logic [CNT_OUT_BITS-1:0] rsp_letter_count,
   output logic [PROB_BITS-1:0]    rsp_probability,
   output logic [ENT_BITS-1:0]     rsp_entropy_bits,
   output logic                    rsp_result_last
);

   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam int SUM_BITS = COUNT_BITS + LOG_BITS + IDX_BITS;
   localparam int DNUM = (SUM_BITS > COUNT_BITS + 16) ? SUM_BITS : COUNT_BITS + 16;

   logic [COUNT_BITS-1:0] bins_ff [NUM_BINS];
   logic [COUNT_BITS-1:0] total_ff, cur_ff;
   logic [LOG_BITS-1:0]   lt_ff;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [DNUM-1:0]       dnum;
   logic [DNUM-1:0]       quot;
   logic [COUNT_BITS-1:0] log_x;
   logic [LOG_BITS-1:0]   log_r;
   logic                  log_done, div_done;
   logic [IDX_BITS-1:0]   idx;
   logic                  is_letter;
   logic [DNUM-1:0]       h_round;
   logic [ENT_BITS-1:0]   h_clamp;
   logic                  have_lt;
   logic                  hdiv_ff;
   logic [LOG_BITS-1:0]   diff;
   logic [PROB_BITS-1:0]  prob_ff;
   logic [ENT_BITS-1:0]   ent_ff;
   logic                  valid_ff, last_ff;
   logic [IDX_BITS-1:0]   oidx_ff;
   logic [CNT_OUT_BITS-1:0] ocnt_ff;

   always_comb begin
      idx       = '0;
      is_letter = 1'b0;
      if (data_byte >= CHAR_LOWER_A && data_byte <= CHAR_LOWER_Z) begin
         idx       = IDX_BITS'(data_byte - CHAR_LOWER_A);
         is_letter = 1'b1;
      end else if (data_byte >= CHAR_UPPER_A && data_byte <= CHAR_UPPER_Z) begin
         idx       = IDX_BITS'(data_byte - CHAR_UPPER_A);
         is_letter = 1'b1;
      end
   end

   // The first log request is for the total, later ones for the loaded bin.
   assign log_x = have_lt ? cur_ff : total_ff;

   lhe_log2 #(.COUNT_BITS(COUNT_BITS)) u_log (
      .clock(clock), .reset(reset), .start(cmd.log_start), .x(log_x),
      .done(log_done), .result(log_r)
   );

   assign dnum = cmd.final_div ? DNUM'(sum_ff) : (DNUM'(cur_ff) << 16);

   lhe_div #(.NUM_BITS(DNUM), .DEN_BITS(COUNT_BITS)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .numer(dnum),
      .denom(total_ff), .done(div_done), .quot(quot)
   );

   assign sts.log_done = log_done;
   assign sts.div_done = div_done;
   assign diff = (lt_ff > log_r) ? (lt_ff - log_r) : '0;

   always_comb begin
      h_round = (quot + DNUM'(1 << (LOG_FRAC - 17))) >> (LOG_FRAC - 16);
      h_clamp = (h_round > DNUM'(ENTROPY_MAX)) ? ENTROPY_MAX : ENT_BITS'(h_round);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) bins_ff[i] <= '0;
         total_ff <= '0;
         have_lt  <= 1'b0;
         hdiv_ff  <= 1'b0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         oidx_ff  <= '0;
         ocnt_ff  <= '0;
         prob_ff  <= '0;
         ent_ff   <= '0;
      end else begin
         valid_ff <= cmd.emit;
         if (cmd.count_en && is_letter) begin
            if (bins_ff[idx] != CMAX) bins_ff[idx] <= bins_ff[idx] + 1'b1;
            if (total_ff != CMAX) total_ff <= total_ff + 1'b1;
         end
         if (log_done && !have_lt) begin
            lt_ff   <= log_r;
            have_lt <= 1'b1;
            sum_ff  <= '0;
         end
         if (cmd.load_bin) cur_ff <= bins_ff[bin_sel];
         if (cmd.accum && cur_ff != '0) begin
            sum_ff <= sum_ff + SUM_BITS'(cur_ff) * SUM_BITS'(diff);
         end
         if (cmd.final_div) hdiv_ff <= 1'b1;
         if (first_bin && cmd.load_bin) ent_ff <= '0;
         // Bin divides give probabilities; the divide after the last bin gives the entropy.
         if (div_done) begin
            if (hdiv_ff) begin
               ent_ff <= (total_ff == '0) ? '0 : h_clamp;
            end else begin
               prob_ff <= (total_ff == '0) ? '0 : PROB_BITS'(quot);
            end
         end
         if (cmd.emit) begin
            oidx_ff <= bin_sel;
            ocnt_ff <= CNT_OUT_BITS'(cur_ff);
            last_ff <= last_bin;
         end
         if (cmd.clear) begin
            for (int i = 0; i < NUM_BINS; i++) bins_ff[i] <= '0;
            total_ff <= '0;
            have_lt  <= 1'b0;
            hdiv_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_letter_index = oidx_ff;
   assign rsp_letter_count = ocnt_ff;
   assign rsp_probability  = prob_ff;
   assign rsp_entropy_bits = last_ff ? ent_ff : '0;
   assign rsp_result_last  = last_ff;

endmodule

/* sv/lhe_checker.sv */
// Port-level checker for the letter histogram entropy block, with its bind.
module lhe_checker
   import lhe_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [IDX_BITS-1:0]  rsp_letter_index,
   input logic [ENT_BITS-1:0]  rsp_entropy_bits,
   input logic                 rsp_result_last
);

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result outside a busy run");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_last |-> rsp_letter_index == IDX_BITS'(NUM_BINS_DEF - 1))
      else $error("last result not on final bin");

   a_ent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_last |-> rsp_entropy_bits == '0)
      else $error("entropy on non-final result");

   a_ent_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entropy_bits <= ENTROPY_MAX)
      else $error("entropy out of range");

endmodule

bind letter_histogram_entropy_top lhe_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_letter_index(rsp_letter_index), .rsp_entropy_bits(rsp_entropy_bits),
   .rsp_result_last(rsp_result_last)
);
